// ----- design/lod_level_select_hysteresis_assert.svh -----
// Assertion macros for the detail level selection block checker.
`ifndef LOD_LEVEL_SELECT_HYSTERESIS_ASSERT_SVH
`define LOD_LEVEL_SELECT_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LODSEL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lodsel: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LODSEL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lodsel: next-cycle check failed");

`endif

// ----- design/lodsel_pkg.sv -----
// Shared constants, register codes and divider stage type for detail level selection.
`default_nettype none

package lodsel_pkg;

	// Level group size and threshold register count
	localparam int MaxLevels = 4;
	localparam int ThrRegs   = 4;

	// Field and datapath widths
	localparam int OffsetW   = 24;
	localparam int MagW      = 24;
	localparam int SqW       = 48;
	localparam int DistW     = 48;
	localparam int RemW      = DistW + 1;
	localparam int Q8W       = 16;
	localparam int HalfW     = 32;
	localparam int NumW      = 64;
	localparam int ScreenW   = 32;
	localparam int ThrW      = 32;
	localparam int BandW     = 16;
	localparam int FactorW   = BandW + 1;
	localparam int ProdW     = ThrW + FactorW;
	localparam int LevelW    = 3;
	localparam int CountRegW = 3;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 32;
	localparam int DivSteps  = ScreenW;

	// Level counter and threshold index widths
	localparam int CntW    = $clog2(MaxLevels + 1);
	localparam int LvlIdxW = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;

	// Fixed-point constants
	localparam logic [DistW-1:0]   OneQ16      = DistW'(65536);
	localparam logic [FactorW-1:0] OneFactor   = FactorW'(65536);
	localparam logic [Q8W-1:0]     ProjReset   = Q8W'(256);
	localparam logic [LevelW-1:0]  LevelNone   = 3'b111;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegProjScaleSq = 3'd0;
	localparam logic [CfgIdxW-1:0] RegHystBand    = 3'd1;
	localparam logic [CfgIdxW-1:0] RegLevelCount  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegThr0        = 3'd3;

	// One stage of the restoring divider plus the side data riding along
	typedef struct packed {
		logic [RemW-1:0]    rem;
		logic [ScreenW-1:0] bits;
		logic [DistW-1:0]   divisor;
		logic               sat;
		logic               en;
		logic [LevelW-1:0]  praw;
	} div_t;

endpackage

`default_nettype wire

// ----- design/lodsel_if.sv -----
// Query and answer channel interfaces for detail level selection.
`default_nettype none

interface lodsel_query_if;
	import lodsel_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [OffsetW-1:0] offset_x;
	logic signed [OffsetW-1:0] offset_y;
	logic signed [OffsetW-1:0] offset_z;
	logic [Q8W-1:0]            object_radius;
	logic [Q8W-1:0]            object_scale;
	logic signed [LevelW-1:0]  present_level;
	logic                      group_enabled;

	modport source (
		output valid, offset_x, offset_y, offset_z, object_radius, object_scale,
		       present_level, group_enabled,
		input  ready
	);
	modport sink (
		input  valid, offset_x, offset_y, offset_z, object_radius, object_scale,
		       present_level, group_enabled,
		output ready
	);
endinterface

interface lodsel_answer_if;
	import lodsel_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [LevelW-1:0] chosen_level;
	logic                     level_changed;
	logic                     restore_original;
	logic [ScreenW-1:0]       proj_size;

	modport source (
		output valid, chosen_level, level_changed, restore_original, proj_size,
		input  ready
	);
	modport sink (
		input  valid, chosen_level, level_changed, restore_original, proj_size,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/lod_level_select_hysteresis.sv -----
// Detail level selection by screen size with hysteresis, top level.
//
// Usage: objects arrive on the query channel (valid/ready), one transaction
// per object; each produces exactly one transaction on the answer channel,
// in order. The configuration port (cfg_we, cfg_index, cfg_data) writes one
// register per cycle and should only be used while no object is in flight.
// Pipeline: an accepted query passes through three stages of squares and
// products, 33 stages of the bit-per-stage divider, then level select,
// hysteresis product and the output register.
// Throughput: one object per cycle unless stalled; the pipeline advances as one.
// Stalls: when the receiver holds ready low, one more answer parks in a skid
// register and the pipeline then freezes with query.ready low, so nothing is
// dropped or repeated; ready returns as soon as the skid drains.
// Reset: all valid bits clear and the registers return to their defaults
// (projection scale 1.0, no dead band, empty group, zero thresholds).
`default_nettype none

module lod_level_select_hysteresis (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lodsel_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [lodsel_pkg::CfgDataW-1:0] cfg_data,
	lodsel_query_if.sink                       query,
	lodsel_answer_if.source                    answer
);
	import lodsel_pkg::*;

	typedef struct packed {
		logic [LevelW-1:0]  chosen;
		logic               changed;
		logic               restore;
		logic [ScreenW-1:0] screen;
	} answer_t;

	// Configuration registers
	logic [Q8W-1:0]       proj_q;
	logic [BandW-1:0]     band_q;
	logic [CountRegW-1:0] lvl_cnt_q;
	logic [ThrW-1:0]      thr_q [MaxLevels];
	logic [CfgIdxW-1:0]   thr_k;
	logic [CntW-1:0]      cnt;

	// Global advance and skid
	logic    adv;
	logic    skid_v_q;
	answer_t skid_q;

	// Stage 1
	logic             v_s1;
	logic [MagW-1:0]  mag_x_s1, mag_y_s1, mag_z_s1;
	logic [HalfW-1:0] rr_s1, ps_s1;
	logic [LevelW-1:0] praw_s1;
	logic             en_s1;
	// Stage 2
	logic             v_s2;
	logic [SqW-1:0]   sq_x_s2, sq_y_s2, sq_z_s2;
	logic [NumW-1:0]  num_s2;
	logic [LevelW-1:0] praw_s2;
	logic             en_s2;
	// Stage 3
	logic             v_s3;
	logic [DistW-1:0] dist_s3;
	logic [NumW-1:0]  num_s3;
	logic [LevelW-1:0] praw_s3;
	logic             en_s3;
	logic [SqW-1:0]   dsum;
	// Divider
	div_t             div_in, div_out;
	logic             div_out_v;
	// Stage 5: level select
	logic [ScreenW-1:0] screen_d;
	logic [CntW-1:0]    tgt_d;
	logic               pres_in_d;
	logic               v_s5;
	logic [ScreenW-1:0] screen_s5;
	logic [CntW-1:0]    tgt_s5;
	logic [LevelW-1:0]  praw_s5;
	logic               en_s5, need_s5, up_s5;
	// Stage 6: dead band product
	logic [LvlIdxW-1:0] sel_idx;
	logic [FactorW-1:0] factor;
	logic               v_s6;
	logic [ScreenW-1:0] screen_s6;
	logic [CntW-1:0]    tgt_s6;
	logic [LevelW-1:0]  praw_s6;
	logic               en_s6, need_s6, up_s6;
	logic [ProdW-1:0]   prod_s6;
	// Output stage
	logic [ProdW-1:0]   scaled;
	logic               keep;
	logic [CntW-1:0]    fin;
	answer_t            res_d;
	logic               ans_v_s7;
	answer_t            ans_s7;
	logic               take, incoming;

	// Configuration writes
	assign thr_k = cfg_index - RegThr0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_q    <= ProjReset;
			band_q    <= '0;
			lvl_cnt_q <= '0;
			for (int i = 0; i < MaxLevels; i++) begin
				thr_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegProjScaleSq: proj_q    <= cfg_data[Q8W-1:0];
				RegHystBand:    band_q    <= cfg_data[BandW-1:0];
				RegLevelCount:  lvl_cnt_q <= cfg_data[CountRegW-1:0];
				default: begin
					if (cfg_index >= RegThr0 && 32'(thr_k) < ThrRegs
					    && 32'(thr_k) < MaxLevels) begin
						thr_q[thr_k[LvlIdxW-1:0]] <= cfg_data[ThrW-1:0];
					end
				end
			endcase
		end
	end

	// Level count clamped to the group size
	assign cnt = (32'(lvl_cnt_q) > MaxLevels) ? CntW'(MaxLevels) : CntW'(lvl_cnt_q);

	// Whole pipeline moves unless the skid holds an answer
	assign adv         = !skid_v_q;
	assign query.ready = adv;

	// Valid bits of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= div_out_v;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: magnitudes, radius squared, projection times scale
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s1 <= query.offset_x[OffsetW-1] ? (~query.offset_x + 1'b1) : query.offset_x;
			mag_y_s1 <= query.offset_y[OffsetW-1] ? (~query.offset_y + 1'b1) : query.offset_y;
			mag_z_s1 <= query.offset_z[OffsetW-1] ? (~query.offset_z + 1'b1) : query.offset_z;
			rr_s1    <= HalfW'(query.object_radius) * HalfW'(query.object_radius);
			ps_s1    <= HalfW'(proj_q) * HalfW'(query.object_scale);
			praw_s1  <= query.present_level;
			en_s1    <= query.group_enabled;
		end
	end

	// Stage 2: squared components and the full numerator
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s2 <= SqW'(mag_x_s1) * SqW'(mag_x_s1);
			sq_y_s2 <= SqW'(mag_y_s1) * SqW'(mag_y_s1);
			sq_z_s2 <= SqW'(mag_z_s1) * SqW'(mag_z_s1);
			num_s2  <= NumW'(rr_s1) * NumW'(ps_s1);
			praw_s2 <= praw_s1;
			en_s2   <= en_s1;
		end
	end

	// Stage 3: distance squared, raised to at least 1.0
	assign dsum = sq_x_s2 + sq_y_s2 + sq_z_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s3 <= (dsum < OneQ16) ? OneQ16 : dsum;
			num_s3  <= num_s2;
			praw_s3 <= praw_s2;
			en_s3   <= en_s2;
		end
	end

	// Divider setup: quotient overflows 32 bits when the high half reaches the divisor
	always_comb begin
		div_in.rem     = RemW'(num_s3[NumW-1:HalfW]);
		div_in.bits    = num_s3[HalfW-1:0];
		div_in.divisor = dist_s3;
		div_in.sat     = (DistW'(num_s3[NumW-1:HalfW]) >= dist_s3);
		div_in.en      = en_s3;
		div_in.praw    = praw_s3;
	end

	lodsel_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.in_data   (div_in),
		.out_valid (div_out_v),
		.out_data  (div_out)
	);

	// Stage 5: saturate, pick the first exceeded threshold
	assign screen_d = div_out.sat ? '1 : div_out.bits;

	always_comb begin
		tgt_d = cnt - CntW'(1);
		for (int i = MaxLevels - 1; i >= 0; i--) begin
			if (32'(i) < 32'(cnt) && screen_d > thr_q[i]) begin
				tgt_d = CntW'(i);
			end
		end
	end

	assign pres_in_d = !div_out.praw[LevelW-1] && (32'(div_out.praw[1:0]) < 32'(cnt));

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_s5 <= screen_d;
			tgt_s5    <= tgt_d;
			praw_s5   <= div_out.praw;
			en_s5     <= div_out.en && (cnt != '0);
			need_s5   <= (band_q != '0) && pres_in_d
			             && (32'(tgt_d) != 32'(div_out.praw[1:0]));
			up_s5     <= (32'(tgt_d) < 32'(div_out.praw[1:0]));
		end
	end

	// Stage 6: band edge of the relevant threshold
	assign sel_idx = up_s5 ? LvlIdxW'(tgt_s5) : LvlIdxW'(praw_s5[1:0]);
	assign factor  = up_s5 ? (OneFactor + FactorW'(band_q)) : (OneFactor - FactorW'(band_q));

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s6   <= ProdW'(thr_q[sel_idx]) * ProdW'(factor);
			screen_s6 <= screen_s5;
			tgt_s6    <= tgt_s5;
			praw_s6   <= praw_s5;
			en_s6     <= en_s5;
			need_s6   <= need_s5;
			up_s6     <= up_s5;
		end
	end

	// Dead band decision and answer fields
	assign scaled = ProdW'({screen_s6, 16'h0000});
	assign keep   = up_s6 ? (scaled <= prod_s6) : (scaled >= prod_s6);
	assign fin    = (need_s6 && keep) ? CntW'(praw_s6[1:0]) : tgt_s6;

	always_comb begin
		if (en_s6) begin
			res_d.chosen  = LevelW'(fin);
			res_d.changed = praw_s6[LevelW-1] || (32'(fin) != 32'(praw_s6[1:0]));
			res_d.restore = 1'b0;
			res_d.screen  = screen_s6;
		end else begin
			res_d.chosen  = LevelNone;
			res_d.changed = !praw_s6[LevelW-1];
			res_d.restore = !praw_s6[LevelW-1];
			res_d.screen  = '0;
		end
	end

	// Output register with skid behind it
	assign take     = !ans_v_s7 || answer.ready;
	assign incoming = adv && v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ans_v_s7 <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				ans_v_s7 <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				ans_v_s7 <= incoming;
			end
		end else if (incoming) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ans_s7 <= skid_v_q ? skid_q : res_d;
		end else if (incoming) begin
			skid_q <= res_d;
		end
	end

	assign answer.valid            = ans_v_s7;
	assign answer.chosen_level     = ans_s7.chosen;
	assign answer.level_changed    = ans_s7.changed;
	assign answer.restore_original = ans_s7.restore;
	assign answer.proj_size        = ans_s7.screen;

endmodule

`default_nettype wire

// ----- design/lodsel_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, 32 stages after the input register.
`default_nettype none

module lodsel_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire lodsel_pkg::div_t  in_data,
	output logic                   out_valid,
	output lodsel_pkg::div_t       out_data
);
	import lodsel_pkg::*;

	div_t              div_s  [DivSteps+1];
	logic [DivSteps:0] dvld_s;

	// Shift in the next dividend bit, subtract the divisor when it fits
	function automatic div_t div_step(input div_t d);
		div_t            r;
		logic [RemW-1:0] t;
		logic            fit;
		r   = d;
		t   = {d.rem[RemW-2:0], d.bits[ScreenW-1]};
		fit = (t >= {1'b0, d.divisor});
		r.rem  = fit ? (t - {1'b0, d.divisor}) : t;
		r.bits = {d.bits[ScreenW-2:0], fit};
		return r;
	endfunction

	// Valid bits travel with each stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s <= '0;
		end else if (adv) begin
			dvld_s <= {dvld_s[DivSteps-1:0], in_valid};
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= in_data;
		end
	end

	// One quotient bit per stage
	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k+1] <= div_step(div_s[k]);
			end
		end
	end

	assign out_valid = dvld_s[DivSteps];
	assign out_data  = div_s[DivSteps];

endmodule

`default_nettype wire

// ----- design/lodsel_chk.sv -----
// Port-level checker for detail level selection, bound to the top level.
`default_nettype none
`include "lod_level_select_hysteresis_assert.svh"

module lodsel_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            a_valid,
	input wire logic                            a_ready,
	input wire logic [lodsel_pkg::LevelW-1:0]   chosen,
	input wire logic                            changed,
	input wire logic                            restore,
	input wire logic [lodsel_pkg::ScreenW-1:0]  screen
);
	import lodsel_pkg::*;

	// A stalled answer keeps its contents
	`LODSEL_ASSERT_NXT(a_hold, clk, arst_n, a_valid && !a_ready, a_valid && $stable(chosen) && $stable(changed) && $stable(restore) && $stable(screen))

	// A restore only comes with the no-level answer and a change
	`LODSEL_ASSERT_IMP(a_restore, clk, arst_n, a_valid && restore, chosen == LevelNone && changed)

	// No-level answers carry zero size and report change and restore together
	`LODSEL_ASSERT_IMP(a_none, clk, arst_n, a_valid && chosen == LevelNone, screen == '0 && changed == restore)

	// Chosen level is a real level or none
	`LODSEL_ASSERT_IMP(a_range, clk, arst_n, a_valid, !chosen[LevelW-1] || chosen == LevelNone)

endmodule

bind lod_level_select_hysteresis lodsel_chk u_lodsel_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.a_valid (answer.valid),
	.a_ready (answer.ready),
	.chosen  (answer.chosen_level),
	.changed (answer.level_changed),
	.restore (answer.restore_original),
	.screen  (answer.proj_size)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for lod_level_select_hysteresis: directed rows, then random phases.
module tb_top;
	import lodsel_pkg::*;

	localparam int QuietLimit  = 2000;
	localparam int DrainCycles = 60;
	localparam int PhaseCount  = 8;
	localparam int MaxReports  = 40;

	// Index with no register behind it, writes must be dropped
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
	// Most negative level code, also means none chosen
	localparam logic [LevelW-1:0] LevelNoneLow = 3'b100;

	typedef struct {
		logic signed [OffsetW-1:0] ox;
		logic signed [OffsetW-1:0] oy;
		logic signed [OffsetW-1:0] oz;
		logic [Q8W-1:0]            radius;
		logic [Q8W-1:0]            scale;
		logic [LevelW-1:0]         present;
		logic                      enabled;
	} query_t;

	typedef struct {
		logic [LevelW-1:0]  level;
		logic               changed;
		logic               restore;
		logic [ScreenW-1:0] screen;
	} answer_t;

	typedef struct {
		bit                  is_cfg;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] data;
		query_t              q;
		bit                  typed;
		answer_t             a;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	lodsel_query_if  query_ch ();
	lodsel_answer_if answer_ch ();

	lod_level_select_hysteresis dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.query     (query_ch),
		.answer    (answer_ch)
	);

	// Shadow copy of the configuration registers
	logic [Q8W-1:0]       proj_sq;
	logic [BandW-1:0]     band;
	logic [CountRegW-1:0] count_reg;
	logic [ThrW-1:0]      thr [MaxLevels];

	answer_t pending_answers[$];
	row_t    directed_rows[$];
	query_t  anchors [MaxLevels];
	answer_t want_answer;
	answer_t no_answer;

	int src_idle_pct;
	int snk_stall_pct;
	int mismatches;
	int answers_seen;
	int queries_sent;
	int cfg_writes;
	int changes_seen;
	int restores_seen;
	int quiet_cycles;
	bit cfg_open;

	initial begin
		forever #2 clk = ~clk;
	end

	// Screen size in Q16.16: proj * r^2 * scale / max(1.0, |offset|^2), saturated
	function automatic logic [ScreenW-1:0] screen_of(query_t q);
		longint sx, sy, sz;
		logic [63:0] range_sq, prod, quo;
		sx = q.ox;
		sy = q.oy;
		sz = q.oz;
		range_sq = 64'(sx * sx + sy * sy + sz * sz);
		if (range_sq < 64'd65536)
			range_sq = 64'd65536;
		prod = 64'(proj_sq) * 64'(q.radius) * 64'(q.radius) * 64'(q.scale);
		quo = prod / range_sq;
		return (quo > 64'hFFFF_FFFF) ? '1 : quo[ScreenW-1:0];
	endfunction

	// Expected answer for one object under the current shadow registers
	function automatic answer_t predict_answer(query_t q);
		answer_t a;
		int pres, levels, target, i;
		logic [ScreenW-1:0] screen;
		logic [63:0] scaled, bound;
		pres = q.present[LevelW-1] ? -1 : int'(q.present);
		levels = (count_reg > MaxLevels) ? MaxLevels : int'(count_reg);
		if (!q.enabled || levels == 0) begin
			a.level = LevelNone;
			a.changed = (pres >= 0);
			a.restore = (pres >= 0);
			a.screen = '0;
			return a;
		end
		screen = screen_of(q);
		// first level whose threshold is strictly exceeded, else the coarsest
		target = levels - 1;
		for (i = levels - 1; i >= 0; i--)
			if (screen > thr[i])
				target = i;
		// dead band around the present level
		if (band != 0 && pres >= 0 && pres < levels && target != pres) begin
			scaled = 64'(screen) << 16;
			if (target < pres) begin
				bound = 64'(thr[target]) * (64'd65536 + 64'(band));
				if (scaled <= bound)
					target = pres;
			end else begin
				bound = 64'(thr[pres]) * (64'd65536 - 64'(band));
				if (scaled >= bound)
					target = pres;
			end
		end
		a.level = target[LevelW-1:0];
		a.changed = (target != pres);
		a.restore = 1'b0;
		a.screen = screen;
		return a;
	endfunction

	function automatic query_t mk_query(logic signed [OffsetW-1:0] ox, logic signed [OffsetW-1:0] oy,
			logic signed [OffsetW-1:0] oz, logic [Q8W-1:0] radius, logic [Q8W-1:0] scale,
			logic [LevelW-1:0] present, logic enabled);
		query_t q;
		q.ox = ox;
		q.oy = oy;
		q.oz = oz;
		q.radius = radius;
		q.scale = scale;
		q.present = present;
		q.enabled = enabled;
		return q;
	endfunction

	function automatic answer_t mk_answer(logic [LevelW-1:0] level, logic changed, logic restore,
			logic [ScreenW-1:0] screen);
		answer_t a;
		a.level = level;
		a.changed = changed;
		a.restore = restore;
		a.screen = screen;
		return a;
	endfunction

	function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic row_t item_row(query_t q);
		row_t r;
		r.is_cfg = 1'b0;
		r.q = q;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic row_t typed_row(query_t q, answer_t a);
		row_t r;
		r = item_row(q);
		r.typed = 1'b1;
		r.a = a;
		return r;
	endfunction

	// Offset with a random magnitude exponent, or fully random bits
	function automatic logic signed [OffsetW-1:0] rand_offset(int hi_exp, bit wild);
		int m;
		if (wild && $urandom_range(0, 1))
			return OffsetW'($urandom());
		m = $urandom_range(0, 1 << $urandom_range(0, hi_exp));
		if ($urandom_range(0, 1))
			m = -m;
		return OffsetW'(m);
	endfunction

	function automatic logic [Q8W-1:0] rand_q8();
		if ($urandom_range(0, 2) == 0)
			return Q8W'($urandom());
		return Q8W'($urandom_range(0, 1 << $urandom_range(4, 12)));
	endfunction

	// Mostly valid levels, some none-chosen and some fully random codes
	function automatic logic [LevelW-1:0] rand_present();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 15)
			return LevelW'($urandom_range(0, MaxLevels - 1));
		if (pick < 17)
			return LevelNone;
		return LevelW'($urandom());
	endfunction

	// Object whose screen size lands on or near one of the thresholds
	function automatic query_t near_anchor();
		query_t q;
		int s;
		q = anchors[$urandom_range(0, MaxLevels - 1)];
		if ($urandom_range(0, 5) != 0) begin
			s = int'(q.scale);
			s = s + int'($urandom_range(0, s / 4 + 1)) - s / 8;
			if (s < 0)
				s = 0;
			if (s > 65535)
				s = 65535;
			q.scale = Q8W'(s);
		end
		q.present = rand_present();
		q.enabled = ($urandom_range(0, 12) != 0);
		return q;
	endfunction

	function automatic query_t noise_query();
		query_t q;
		q.ox = rand_offset(22, 1'b1);
		q.oy = rand_offset(22, 1'b1);
		q.oz = rand_offset(22, 1'b1);
		q.radius = rand_q8();
		q.scale = rand_q8();
		q.present = LevelW'($urandom());
		q.enabled = ($urandom_range(0, 3) != 0);
		return q;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("answer %0d: %s got %0h expected %0h", answers_seen, what, got, want);
	endtask

	// One register write; the shadow copy follows it
	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			RegProjScaleSq: proj_sq = data[Q8W-1:0];
			RegHystBand:    band = data[BandW-1:0];
			RegLevelCount:  count_reg = data[CountRegW-1:0];
			default: begin
				if (int'(idx) >= int'(RegThr0) && int'(idx) < int'(RegThr0) + ThrRegs)
					thr[int'(idx) - int'(RegThr0)] = data;
			end
		endcase
		cfg_open = 1'b1;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic cfg_close();
		if (cfg_open) begin
			cfg_we <= 1'b0;
			cfg_open = 1'b0;
		end
	endtask

	// Drop valid and hold off until every expected answer is back
	task automatic go_quiet();
		query_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Present one object, with random idle cycles ahead of it
	task automatic push_query(query_t q, bit typed, answer_t a);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			query_ch.valid <= 1'b0;
			@(posedge clk);
		end
		query_ch.valid <= 1'b1;
		query_ch.offset_x <= q.ox;
		query_ch.offset_y <= q.oy;
		query_ch.offset_z <= q.oz;
		query_ch.object_radius <= q.radius;
		query_ch.object_scale <= q.scale;
		query_ch.present_level <= q.present;
		query_ch.group_enabled <= q.enabled;
		do
			@(posedge clk);
		while (!query_ch.ready);
		if (typed)
			pending_answers.push_back(a);
		else
			pending_answers.push_back(predict_answer(q));
		queries_sent++;
	endtask

	// New register set for a random phase; thresholds come from anchor screen sizes
	task automatic setup_phase(int ph);
		logic [Q8W-1:0]       p;
		logic [BandW-1:0]     b;
		logic [CountRegW-1:0] c;
		logic [ScreenW-1:0]   ladder [MaxLevels];
		logic [ScreenW-1:0]   t;
		int i, j;
		go_quiet();
		p = ($urandom_range(0, 3) == 0) ? Q8W'($urandom()) : Q8W'($urandom_range(64, 2048));
		b = ($urandom_range(0, 4) == 0) ? '0 : BandW'($urandom_range(1, 16384));
		c = ($urandom_range(0, 5) == 0) ? CountRegW'($urandom()) : CountRegW'($urandom_range(1, 4));
		case (ph)
			0: begin
				p = '1;
				b = '1;
				c = '1;
			end
			1: begin
				p = '0;
				b = '0;
				c = CountRegW'(1);
			end
			5: c = '0;
			default: ;
		endcase
		cfg_write(RegProjScaleSq, {16'($urandom()), p});
		cfg_write(RegHystBand, {16'($urandom()), b});
		cfg_write(RegLevelCount, {29'($urandom()), c});
		cfg_write(RegUnused, $urandom());
		for (i = 0; i < MaxLevels; i++) begin
			anchors[i] = mk_query(rand_offset(16, 1'b0), rand_offset(16, 1'b0), rand_offset(16, 1'b0),
				Q8W'($urandom_range(64, 4096)), Q8W'($urandom_range(256, 4096)), '0, 1'b1);
			ladder[i] = screen_of(anchors[i]);
		end
		// finest level gets the largest threshold
		for (i = 0; i < MaxLevels; i++)
			for (j = i + 1; j < MaxLevels; j++)
				if (ladder[j] > ladder[i]) begin
					t = ladder[i];
					ladder[i] = ladder[j];
					ladder[j] = t;
				end
		// now and then an out-of-order ladder
		if ($urandom_range(0, 3) == 0)
			ladder[$urandom_range(0, MaxLevels - 1)] = $urandom();
		for (i = 0; i < MaxLevels; i++)
			cfg_write(RegThr0 + CfgIdxW'(i), ladder[i]);
		cfg_close();
	endtask

	// Receiver: random back-pressure at the current stall rate
	always @(posedge clk)
		answer_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// Answer checker: each accepted transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && answer_ch.valid && answer_ch.ready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected answer", 0, 0);
			end else begin
				want_answer = pending_answers.pop_front();
				if (answer_ch.chosen_level !== want_answer.level)
					report_mismatch("chosen_level", $signed(answer_ch.chosen_level),
						$signed(want_answer.level));
				if (answer_ch.level_changed !== want_answer.changed)
					report_mismatch("level_changed", answer_ch.level_changed, want_answer.changed);
				if (answer_ch.restore_original !== want_answer.restore)
					report_mismatch("restore_original", answer_ch.restore_original,
						want_answer.restore);
				if (answer_ch.proj_size !== want_answer.screen)
					report_mismatch("proj_size", answer_ch.proj_size, want_answer.screen);
				changes_seen += want_answer.changed;
				restores_seen += want_answer.restore;
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((query_ch.valid && query_ch.ready) || (answer_ch.valid && answer_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("lod_level_select_hysteresis regression: fail");
			$finish;
		end
	end

	initial begin
		int ph, n, len, directed_count;
		bit streaming;

		// known values on every input from time zero
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		query_ch.valid = 1'b0;
		query_ch.offset_x = '0;
		query_ch.offset_y = '0;
		query_ch.offset_z = '0;
		query_ch.object_radius = '0;
		query_ch.object_scale = '0;
		query_ch.present_level = '0;
		query_ch.group_enabled = 1'b0;
		answer_ch.ready = 1'b0;
		proj_sq = ProjReset;
		band = '0;
		count_reg = '0;
		for (n = 0; n < MaxLevels; n++)
			thr[n] = '0;
		no_answer = mk_answer('0, 1'b0, 1'b0, '0);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		mismatches = 0;
		answers_seen = 0;
		queries_sent = 0;
		cfg_writes = 0;
		changes_seen = 0;
		restores_seen = 0;
		quiet_cycles = 0;
		cfg_open = 1'b0;
		streaming = 1'b0;

		// Directed rows. Empty group after reset: always level -1, screen 0
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, 16'h0100, 16'h0100, 3'd2, 1'b1),
			mk_answer(LevelNone, 1'b1, 1'b1, '0)));
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, 16'h0100, 16'h0100, LevelNone, 1'b1),
			mk_answer(LevelNone, 1'b0, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, 16'h0100, 16'h0100, 3'd0, 1'b0),
			mk_answer(LevelNone, 1'b1, 1'b1, '0)));
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, 16'h0100, 16'h0100, LevelNoneLow, 1'b1),
			mk_answer(LevelNone, 1'b0, 1'b0, '0)));
		// write to the unused index is dropped, group stays empty
		directed_rows.push_back(cfg_row(RegUnused, '1));
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, 16'h0100, 16'h0100, 3'd1, 1'b1),
			mk_answer(LevelNone, 1'b1, 1'b1, '0)));
		// oversized level count clamps to four; full projection scale
		directed_rows.push_back(cfg_row(RegLevelCount, 32'd7));
		directed_rows.push_back(cfg_row(RegThr0, 32'h0004_0000));
		directed_rows.push_back(cfg_row(RegThr0 + CfgIdxW'(1), 32'h0001_0000));
		directed_rows.push_back(cfg_row(RegThr0 + CfgIdxW'(2), 32'h0000_4000));
		directed_rows.push_back(cfg_row(RegThr0 + CfgIdxW'(3), 32'h0000_1000));
		directed_rows.push_back(cfg_row(RegProjScaleSq, 32'h0000_FFFF));
		// zero offset clamps to 1.0 and the product saturates
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, '1, '1, 3'd3, 1'b1),
			mk_answer(3'd0, 1'b1, 1'b0, '1)));
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, '0, '1, 3'd3, 1'b1),
			mk_answer(3'd3, 1'b0, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_query(0, 0, 0, '0, '1, 3'd1, 1'b1),
			mk_answer(3'd3, 1'b1, 1'b0, '0)));
		directed_rows.push_back(item_row(mk_query(24'sh800000, 24'sh800000, 24'sh800000, '1, '1,
			3'd0, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh7FFFFF, 0, 0, '1, '1, 3'd2, 1'b1)));
		// dead band of one eighth around 1.0 (offset 1.0, radius 1.0)
		directed_rows.push_back(cfg_row(RegProjScaleSq, 32'h0000_0100));
		directed_rows.push_back(cfg_row(RegHystBand, 32'h0000_2000));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd282, 3'd2, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd300, 3'd2, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd240, 3'd1, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd200, 3'd1, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd256, LevelNone,
			1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd256, 3'd2, 1'b1)));
		// present level beyond the count skips the band
		directed_rows.push_back(cfg_row(RegLevelCount, 32'd2));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd200, 3'd3, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd4096, 3'd1, 1'b1)));
		// widest band
		directed_rows.push_back(cfg_row(RegHystBand, 32'h0000_FFFF));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd200, 3'd0, 1'b1)));
		directed_rows.push_back(item_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd1100, 3'd1, 1'b1)));
		directed_rows.push_back(typed_row(mk_query(24'sh000100, 0, 0, 16'h0100, 16'd256, 3'd1, 1'b0),
			mk_answer(LevelNone, 1'b1, 1'b1, '0)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		foreach (directed_rows[r]) begin
			if (directed_rows[r].is_cfg) begin
				if (streaming)
					go_quiet();
				streaming = 1'b0;
				cfg_write(directed_rows[r].idx, directed_rows[r].data);
			end else begin
				cfg_close();
				push_query(directed_rows[r].q, directed_rows[r].typed, directed_rows[r].a);
				streaming = 1'b1;
			end
		end
		directed_count = queries_sent;

		// Random phases: idle patterns cycle through none, sender, receiver, both
		for (ph = 0; ph < PhaseCount; ph++) begin
			setup_phase(ph);
			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 48;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 48;
				end
				default: begin
					src_idle_pct = 34;
					snk_stall_pct = 34;
				end
			endcase
			len = (ph == 1 || ph == 5) ? 40 : 195;
			for (n = 0; n < len; n++) begin
				if ($urandom_range(0, 149) == 0)
					go_quiet();
				if ($urandom_range(0, 99) < 65)
					push_query(near_anchor(), 1'b0, no_answer);
				else
					push_query(noise_query(), 1'b0, no_answer);
			end
		end

		// Drain and let the pipeline settle
		go_quiet();
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d objects (%0d directed), %0d answers, %0d register writes",
			queries_sent, directed_count, answers_seen, cfg_writes);
		$display("%0d answers moved the level, %0d restored the original mesh, %0d mismatches",
			changes_seen, restores_seen, mismatches);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("lod_level_select_hysteresis regression: pass");
		else
			$display("lod_level_select_hysteresis regression: fail");
		$finish;
	end

endmodule
